/* hdl/wdr_pkg.sv */
// ----------------------------------------------------------------------------
// wdr_pkg
// shared types and constants for the 256-bit divider with remainder
// ----------------------------------------------------------------------------
package wdr_pkg;

  localparam int LIMB_W   = 64;
  localparam int NUM_LIMB = 4;
  localparam int OPER_W   = LIMB_W * NUM_LIMB;
  localparam int IN_W     = 2 * OPER_W;
  localparam int OUT_W    = 2 * OPER_W;
  localparam int USER_W   = 1;
  localparam int CNT_W    = $clog2(OPER_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OPER_W - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_HOLD
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } ctl_t;

endpackage

/* hdl/wdr_div_unit.sv */
// ----------------------------------------------------------------------------
// wdr_div_unit
// restoring divide datapath: one shared 257-bit trial subtract per cycle while ctl.step is set,
// one quotient bit per step shifted in behind the dividend bits
// ----------------------------------------------------------------------------
module wdr_div_unit (
  input  logic                       clk,
  input  wdr_pkg::ctl_t              ctl,
  input  logic [wdr_pkg::OPER_W-1:0] dividend,
  input  logic [wdr_pkg::OPER_W-1:0] divisor,
  output logic [wdr_pkg::OPER_W-1:0] quotient,
  output logic [wdr_pkg::OPER_W-1:0] remainder
);

  logic [wdr_pkg::OPER_W-1:0] rem_r, rem_nxt;
  logic [wdr_pkg::OPER_W-1:0] quo_r, quo_nxt;
  logic [wdr_pkg::OPER_W-1:0] dvs_r;
  logic [wdr_pkg::OPER_W:0]   trial;
  logic [wdr_pkg::OPER_W+1:0] diff;
  logic                       borrow;

  assign trial  = {rem_r, quo_r[wdr_pkg::OPER_W-1]};
  assign diff   = {1'b0, trial} - {2'b00, dvs_r};
  assign borrow = diff[wdr_pkg::OPER_W+1];

  always_comb begin
    rem_nxt = borrow ? trial[wdr_pkg::OPER_W-1:0] : diff[wdr_pkg::OPER_W-1:0];
    quo_nxt = {quo_r[wdr_pkg::OPER_W-2:0], ~borrow};
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (ctl.step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

/* hdl/wide_divide_with_remainder_top.sv */
// ----------------------------------------------------------------------------
// wide_divide_with_remainder_top
// unsigned 256-bit divide giving floor quotient and remainder
//
//   channel | direction | tdata (low bit first)              | tuser
//   in_     | slave     | dividend limb0..3, divisor limb0..3 | -
//   out_    | master    | quotient limb0..3, remainder 0..3   | divide_by_zero
//
// out_tvalid rises after the input transfer once the sequencer has run 256 steps of the
// shared trial subtractor, one bit each, and the hold state has loaded the result register
// a zero divisor skips the steps and goes from idle straight to the hold state
// in_tready is high only in the idle state, which the hold state returns to
// the result sits in an output register, so a new item is taken while it waits;
// the hold state stalls until that register is free
// rst_n is synchronous, active low, and clears the sequencer and out_tvalid
// ----------------------------------------------------------------------------
module wide_divide_with_remainder_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [wdr_pkg::IN_W-1:0]   in_tdata,   // dividend_limb0..3, divisor_limb0..3
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [wdr_pkg::OUT_W-1:0]  out_tdata,  // quotient_limb0..3, remainder_limb0..3
  output logic [wdr_pkg::USER_W-1:0] out_tuser   // divide_by_zero
);

  wdr_pkg::state_t             state_r, state_nxt;
  wdr_pkg::ctl_t               ctl;
  logic [wdr_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                        dbz_r, dbz_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [wdr_pkg::OUT_W-1:0]   out_data_r;
  logic [wdr_pkg::USER_W-1:0]  out_user_r;
  logic                        in_xfer;
  logic                        out_load;
  logic                        in_dbz;
  logic [wdr_pkg::OPER_W-1:0]  dividend;
  logic [wdr_pkg::OPER_W-1:0]  divisor;
  logic [wdr_pkg::OPER_W-1:0]  quotient;
  logic [wdr_pkg::OPER_W-1:0]  remainder;

  assign dividend = in_tdata[wdr_pkg::OPER_W-1:0];
  assign divisor  = in_tdata[wdr_pkg::IN_W-1:wdr_pkg::OPER_W];
  assign in_dbz   = (divisor == '0);
  assign in_xfer  = in_tvalid && in_tready;

  wdr_div_unit u_div (
    .clk       (clk),
    .ctl       (ctl),
    .dividend  (dividend),
    .divisor   (divisor),
    .quotient  (quotient),
    .remainder (remainder)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wdr_pkg::S_IDLE: begin
        if (in_xfer) begin
          state_nxt = in_dbz ? wdr_pkg::S_HOLD : wdr_pkg::S_RUN;
        end
      end
      wdr_pkg::S_RUN: begin
        if (cnt_r == wdr_pkg::CNT_LAST) begin
          state_nxt = wdr_pkg::S_HOLD;
        end
      end
      wdr_pkg::S_HOLD: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = wdr_pkg::S_IDLE;
        end
      end
      default: state_nxt = wdr_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    ctl.step  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      wdr_pkg::S_IDLE: in_tready = 1'b1;
      wdr_pkg::S_RUN:  ctl.step  = 1'b1;
      wdr_pkg::S_HOLD: out_load  = !out_valid_r || out_tready;
      default: begin
        in_tready = 1'b0;
        ctl.step  = 1'b0;
        out_load  = 1'b0;
      end
    endcase
    ctl.load = in_xfer;
  end

  always_comb begin
    cnt_nxt = ctl.load ? '0 : (ctl.step ? cnt_r + 1'b1 : cnt_r);
    dbz_nxt = ctl.load ? in_dbz : dbz_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wdr_pkg::S_IDLE;
      cnt_r       <= '0;
      dbz_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      dbz_r       <= dbz_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result register, zeros on divide by zero
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= dbz_r ? '0 : {remainder, quotient};
      out_user_r <= dbz_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

/* hdl/wdr_checker.sv */
// ----------------------------------------------------------------------------
// wdr_checker
// port-level checks for the 256-bit divider, bound to the top level
// ----------------------------------------------------------------------------
module wdr_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [wdr_pkg::OUT_W-1:0]  out_tdata,
  input logic [wdr_pkg::USER_W-1:0] out_tuser
);

  // a waiting result is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped before transfer");

  // divide by zero gives an all-zero result
  a_dbz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("divide by zero result not zero");

  // busy right after taking an item
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready right after input transfer");

endmodule

bind wide_divide_with_remainder_top wdr_checker u_wdr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
